[sv/lpg_pkg.sv]
// Shared types and constants for the lexicographic permutation generator.
package lpg_pkg;

   localparam int ELEMENT_W       = 4;
   localparam int POSITION_W      = 3;
   localparam int SIZE_W          = 4;
   localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RESET = 4'd8;
   localparam int CMD_QUEUE_DEPTH = 2;

   typedef enum logic {
      CMD_IDENTITY,
      CMD_ADVANCE
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_SWAP,
      ST_REVERSE,
      ST_EMIT,
      ST_EXHAUST
   } back_state_type;

   typedef struct packed {
      logic restart;
   } req_payload_type;

   typedef struct packed {
      logic [ELEMENT_W-1:0]  element_value;
      logic [POSITION_W-1:0] element_position;
      logic                  last_element;
      logic                  final_permutation;
      logic                  exhausted;
   } rsp_payload_type;

endpackage

[sv/lpg_stream_if.sv]
// Valid/ready stream interface carrying one payload word per handshake.
interface lpg_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[sv/lpg_front.sv]
// Front end: size register, request classification, command push.
module lpg_front #(
   parameter int MAX_ELEMENTS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   lpg_stream_if.sink                      req,
   input  logic                            csr_write_enable,
   input  logic [lpg_pkg::SIZE_W-1:0]      csr_write_data,
   input  logic                            queue_full,
   output lpg_pkg::cmd_entry_type          push,
   output logic [$clog2(MAX_ELEMENTS+1)-1:0] size_n
);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

   logic [lpg_pkg::SIZE_W-1:0] active_size_ff, active_size_in;
   logic                       first_pending_ff, first_pending_in;
   logic                       accept;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      push.valid = accept;
      push.cmd   = (req.payload.restart || first_pending_ff) ? lpg_pkg::CMD_IDENTITY
                                                             : lpg_pkg::CMD_ADVANCE;
   end

   always_comb begin
      active_size_in   = active_size_ff;
      first_pending_in = first_pending_ff;
      if (accept) begin
         first_pending_in = 1'b0;
      end
      if (csr_write_enable) begin
         active_size_in   = csr_write_data;
         first_pending_in = 1'b1;
      end
   end

   // clamp the size into 1..MAX_ELEMENTS
   always_comb begin
      if (active_size_ff == '0) begin
         size_n = CNT_W'(1);
      end else if (32'(active_size_ff) > MAX_ELEMENTS) begin
         size_n = CNT_W'(MAX_ELEMENTS);
      end else begin
         size_n = CNT_W'(active_size_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_size_ff   <= lpg_pkg::ACTIVE_SIZE_RESET;
         first_pending_ff <= 1'b1;
      end else begin
         active_size_ff   <= active_size_in;
         first_pending_ff <= first_pending_in;
      end
   end
endmodule

[sv/lpg_cmd_queue.sv]
// Short command queue between front end and back end.
module lpg_cmd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  lpg_pkg::cmd_entry_type push,
   output logic                   full,
   output lpg_pkg::cmd_entry_type pop,
   input  logic                   pop_ready
);
   localparam int DEPTH = lpg_pkg::CMD_QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lpg_pkg::cmd_type    slots_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop.valid = (count_ff != '0);
   assign pop.cmd   = slots_ff[rd_ptr_ff];
   assign do_push   = push.valid && !full;
   assign do_pop    = pop.valid && pop_ready;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      bump = (32'(p) == DEPTH - 1) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

[sv/lpg_back.sv]
// Back end: permutation register, next-permutation sequencer, element output.
module lpg_back #(
   parameter int MAX_ELEMENTS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lpg_pkg::cmd_entry_type            pop,
   output logic                              pop_ready,
   input  logic [$clog2(MAX_ELEMENTS+1)-1:0] size_n,
   input  logic                              size_write,
   lpg_stream_if.source                      rsp
);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int SRC_W = CNT_W + 1;
   localparam int EW    = lpg_pkg::ELEMENT_W;

   lpg_pkg::back_state_type state_ff, state_in;
   logic [EW-1:0]           order_ff [MAX_ELEMENTS];
   logic [EW-1:0]           order_in [MAX_ELEMENTS];
   logic [IDX_W-1:0]        pivot_ff, pivot_in;
   logic [IDX_W-1:0]        pos_ff, pos_in;
   logic                    done_ff, done_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   lpg_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [MAX_ELEMENTS-2:0] ascent;
   logic                    has_ascent;
   logic [IDX_W-1:0]        ascent_idx;
   logic [EW-1:0]           pivot_value;
   logic [IDX_W-1:0]        swap_idx;
   logic [SRC_W-1:0]        src;
   logic                    out_free;
   logic                    last_pos;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign last_pos  = (CNT_W'(pos_ff) + CNT_W'(1) == size_n);
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   // adjacent ascents inside the active size; highest one is the pivot
   always_comb begin
      ascent_idx = '0;
      for (int k = 0; k < MAX_ELEMENTS - 1; k++) begin
         ascent[k] = (CNT_W'(k + 1) < size_n) && (order_ff[k] < order_ff[k + 1]);
         if (ascent[k]) begin
            ascent_idx = IDX_W'(k);
         end
      end
      has_ascent = |ascent;
   end

   // rightmost element after the pivot that is larger than it
   always_comb begin
      pivot_value = order_ff[pivot_ff];
      swap_idx    = pivot_ff + IDX_W'(1);
      for (int k = 0; k < MAX_ELEMENTS; k++) begin
         if ((IDX_W'(k) > pivot_ff) && (CNT_W'(k) < size_n) &&
             (order_ff[k] > pivot_value)) begin
            swap_idx = IDX_W'(k);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpg_pkg::ST_IDLE: begin
            if (pop.valid) begin
               if (pop.cmd == lpg_pkg::CMD_IDENTITY) begin
                  state_in = lpg_pkg::ST_EMIT;
               end else if (done_ff) begin
                  state_in = lpg_pkg::ST_EXHAUST;
               end else begin
                  state_in = lpg_pkg::ST_FIND;
               end
            end
         end
         lpg_pkg::ST_FIND:    state_in = has_ascent ? lpg_pkg::ST_SWAP : lpg_pkg::ST_EMIT;
         lpg_pkg::ST_SWAP:    state_in = lpg_pkg::ST_REVERSE;
         lpg_pkg::ST_REVERSE: state_in = lpg_pkg::ST_EMIT;
         lpg_pkg::ST_EMIT: begin
            if (out_free && last_pos) begin
               state_in = lpg_pkg::ST_IDLE;
            end
         end
         lpg_pkg::ST_EXHAUST: begin
            if (out_free) begin
               state_in = lpg_pkg::ST_IDLE;
            end
         end
         default: state_in = lpg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      order_in     = order_ff;
      pivot_in     = pivot_ff;
      pos_in       = pos_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      pop_ready    = 1'b0;
      src          = '0;
      unique case (state_ff)
         lpg_pkg::ST_IDLE: begin
            pop_ready = 1'b1;
            pos_in    = '0;
            if (pop.valid && pop.cmd == lpg_pkg::CMD_IDENTITY) begin
               done_in = 1'b0;
               for (int k = 0; k < MAX_ELEMENTS; k++) begin
                  order_in[k] = EW'(k + 1);
               end
            end
         end
         lpg_pkg::ST_FIND: begin
            pivot_in = ascent_idx;
         end
         lpg_pkg::ST_SWAP: begin
            order_in[pivot_ff] = order_ff[swap_idx];
            order_in[swap_idx] = pivot_value;
         end
         lpg_pkg::ST_REVERSE: begin
            for (int k = 0; k < MAX_ELEMENTS; k++) begin
               src = SRC_W'(pivot_ff) + SRC_W'(size_n) - SRC_W'(k);
               if ((IDX_W'(k) > pivot_ff) && (CNT_W'(k) < size_n)) begin
                  order_in[k] = order_ff[src[IDX_W-1:0]];
               end
            end
         end
         lpg_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in                  = 1'b1;
               rsp_data_in.element_value     = order_ff[pos_ff];
               rsp_data_in.element_position  = lpg_pkg::POSITION_W'(pos_ff);
               rsp_data_in.last_element      = last_pos;
               rsp_data_in.final_permutation = !has_ascent;
               rsp_data_in.exhausted         = 1'b0;
               pos_in                        = pos_ff + IDX_W'(1);
               if (last_pos && !has_ascent) begin
                  done_in = 1'b1;
               end
            end
         end
         lpg_pkg::ST_EXHAUST: begin
            if (out_free) begin
               rsp_valid_in                  = 1'b1;
               rsp_data_in.element_value     = '0;
               rsp_data_in.element_position  = '0;
               rsp_data_in.last_element      = 1'b1;
               rsp_data_in.final_permutation = 1'b0;
               rsp_data_in.exhausted         = 1'b1;
            end
         end
         default: begin
            pop_ready = 1'b0;
         end
      endcase
      if (size_write) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      pivot_ff    <= pivot_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpg_pkg::ST_IDLE;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_ELEMENTS; k++) begin
            order_ff[k] <= EW'(k + 1);
         end
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         order_ff     <= order_in;
      end
   end
endmodule

[sv/lexicographic_permutation_generator.sv]
// Top level of the lexicographic permutation generator.
//
// Each word on req asks for one permutation of 1..n, n being the size set
// through csr_write_enable / csr_write_data (0 acts as 1, values above
// MAX_ELEMENTS act as MAX_ELEMENTS). restart = 1, the first request after
// reset and the first request after any size write give the identity;
// otherwise the block steps to the next permutation in lexicographic order.
// The answer is n words on rsp, one per element, the last one flagged;
// once the descending permutation is out, each further plain request
// returns a single exhausted word.
// Timing: the front end classifies a request in the accept cycle and
// queues it (two deep); the back end pops it once it is idle. An identity
// request then streams n words at one per cycle while rsp is not stalled;
// an advance first steps through pivot search, swap and tail reversal;
// an exhausted reply is a single word. Back-end sequencing sets the rate.
// Reset loads the identity, sets size 8 and empties the queue.
// A stall on rsp holds the output register and the back end; the queue
// keeps taking requests until it fills, then req.ready drops.
module lexicographic_permutation_generator #(
   parameter int MAX_ELEMENTS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   lpg_stream_if.sink                   req,
   lpg_stream_if.source                 rsp,
   input  logic                         csr_write_enable,
   input  logic [lpg_pkg::SIZE_W-1:0]   csr_write_data
);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

   lpg_pkg::cmd_entry_type push;
   lpg_pkg::cmd_entry_type pop;
   logic                   queue_full;
   logic                   pop_ready;
   logic [CNT_W-1:0]       size_n;

   // classify requests and hold the size register
   lpg_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push             (push),
      .size_n           (size_n)
   );

   // decouple the two halves so either side may stall
   lpg_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (queue_full),
      .pop       (pop),
      .pop_ready (pop_ready)
   );

   // advance the permutation and stream its elements
   lpg_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop        (pop),
      .pop_ready  (pop_ready),
      .size_n     (size_n),
      .size_write (csr_write_enable),
      .rsp        (rsp)
   );
endmodule

[tb/sv/lpg_tb_pkg.sv]
// Scoreboard for the permutation generator: next-permutation predictor and word check.
package lpg_tb_pkg;

   import lpg_pkg::*;

   localparam int MAX_ORDER    = 8;
   localparam int REPORT_LIMIT = 10;

   class permutation_tracker_type;

      logic [ELEMENT_W-1:0] order [MAX_ORDER];
      logic [SIZE_W-1:0]    size_reg;
      bit                   first_pending;
      bit                   sequence_done;
      rsp_payload_type      pending_words [$];

      int requests_noted;
      int words_checked;
      int orders_seen;
      int descending_seen;
      int exhausted_seen;
      int mismatches;

      function new();
         size_reg      = ACTIVE_SIZE_RESET;
         first_pending = 1'b1;
         sequence_done = 1'b0;
         load_identity();
      endfunction

      function void load_identity();
         for (int k = 0; k < MAX_ORDER; k++) order[k] = ELEMENT_W'(k + 1);
      endfunction

      // Size 0 acts as 1, anything above the element count as the maximum.
      function int active_count();
         if (size_reg == 0) return 1;
         if (size_reg > MAX_ORDER) return MAX_ORDER;
         return int'(size_reg);
      endfunction

      // Rightmost ascent; n when the order is fully descending.
      function int pivot_index(input int n);
         int pos;
         pos = n;
         for (int k = 0; k + 1 < n; k++)
            if (order[k] < order[k + 1]) pos = k;
         return pos;
      endfunction

      function void step_order(input int n);
         int                   i;
         int                   j;
         int                   lo;
         int                   hi;
         logic [ELEMENT_W-1:0] t;
         i = pivot_index(n);
         if (i >= n) return;
         j = i + 1;
         for (int k = i + 1; k < n; k++)
            if (order[k] > order[i]) j = k;
         t        = order[i];
         order[i] = order[j];
         order[j] = t;
         lo = i + 1;
         hi = n - 1;
         while (lo < hi) begin
            t         = order[lo];
            order[lo] = order[hi];
            order[hi] = t;
            lo++;
            hi--;
         end
      endfunction

      // Add one expected word at the tail.
      function void append_word(input rsp_payload_type w);
         pending_words = {pending_words, w};
      endfunction

      function void queue_order(input int n);
         rsp_payload_type w;
         bit              descending;
         descending = (pivot_index(n) >= n);
         for (int k = 0; k < n; k++) begin
            w.element_value     = order[k];
            w.element_position  = POSITION_W'(k);
            w.last_element      = (k == n - 1);
            w.final_permutation = descending;
            w.exhausted         = 1'b0;
            append_word(w);
         end
         if (descending) sequence_done = 1'b1;
      endfunction

      function void note_request(input bit restart);
         rsp_payload_type w;
         int              n;
         n = active_count();
         requests_noted++;
         if (restart || first_pending) begin
            load_identity();
            first_pending = 1'b0;
            sequence_done = 1'b0;
            queue_order(n);
         end else if (sequence_done) begin
            w.element_value     = '0;
            w.element_position  = '0;
            w.last_element      = 1'b1;
            w.final_permutation = 1'b0;
            w.exhausted         = 1'b1;
            append_word(w);
         end else begin
            step_order(n);
            queue_order(n);
         end
      endfunction

      function void note_size_write(input logic [SIZE_W-1:0] value);
         size_reg      = value;
         first_pending = 1'b1;
         sequence_done = 1'b0;
      endfunction

      function int pending_count();
         return pending_words.size();
      endfunction

      function void check_word(input rsp_payload_type got);
         rsp_payload_type want;
         bit              bad;
         if (got.exhausted === 1'b1) exhausted_seen++;
         else if (got.last_element === 1'b1) begin
            orders_seen++;
            if (got.final_permutation === 1'b1) descending_seen++;
         end
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected word: value %0d pos %0d last %b final %b exh %b",
                        got.element_value, got.element_position, got.last_element,
                        got.final_permutation, got.exhausted);
            return;
         end
         want = pending_words.pop_front();
         words_checked++;
         bad = (got.element_value     !== want.element_value)     ||
               (got.element_position  !== want.element_position)  ||
               (got.last_element      !== want.last_element)      ||
               (got.final_permutation !== want.final_permutation) ||
               (got.exhausted         !== want.exhausted);
         if (bad) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("mismatch: want %0d/%0d/%b/%b/%b got %0d/%0d/%b/%b/%b",
                        want.element_value, want.element_position, want.last_element,
                        want.final_permutation, want.exhausted,
                        got.element_value, got.element_position, got.last_element,
                        got.final_permutation, got.exhausted);
         end
      endfunction

   endclass

endpackage

[tb/sv/lexicographic_permutation_generator_tb.sv]
// Top-level testbench for the lexicographic permutation generator.
module lexicographic_permutation_generator_tb;

   import lpg_pkg::*;
   import lpg_tb_pkg::*;

   localparam int RESET_CYCLES    = 11;
   localparam int RANDOM_REQUESTS = 195;
   localparam int SETTLE_CYCLES   = 12;
   localparam int TAIL_CYCLES     = 40;
   localparam int HOLD_CYCLES     = 400;
   localparam int QUIET_LIMIT     = 4000; // well above the hold-off and any random gap

   typedef enum int {
      IDLE_NONE,
      IDLE_FULL,
      IDLE_SPARSE
   } idle_kind_type;

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic [SIZE_W-1:0] csr_write_data;

   lpg_stream_if #(.payload_type(req_payload_type)) req_if ();
   lpg_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   lexicographic_permutation_generator #(
      .MAX_ELEMENTS(MAX_ORDER)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   permutation_tracker_type tracker;
   idle_kind_type           idle_mode;
   bit                      hold_rsp;
   int                      quiet_cycles;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Draw the wait before the next word on either side; the mode decides
   // whether this phase runs back to back, fully ragged or mostly tight.
   function automatic int draw_gap();
      case (idle_mode)
         IDLE_NONE: return 0;
         IDLE_FULL: return $urandom_range(0, 19);
         default: begin
            if ($urandom_range(0, 3) == 0) return $urandom_range(0, 19);
            return 0;
         end
      endcase
   endfunction

   // Mostly small sizes so whole sequences run out; a few larger, zero
   // and out-of-range writes keep the clamping honest.
   function automatic logic [SIZE_W-1:0] pick_size();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return SIZE_W'($urandom_range(9, 15));
      if (r <= 4) return SIZE_W'($urandom_range(5, 8));
      return SIZE_W'($urandom_range(1, 4));
   endfunction

   // Offer one request word and hold it until accepted. Valid is only
   // dropped when a gap is drawn, so back-to-back words keep it high.
   task automatic send_request(input bit restart);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= '{restart: restart};
      do @(posedge clock); while (req_if.ready !== 1'b1);
      tracker.note_request(restart);
   endtask

   // Write the size register only once every expected word is back and the
   // back end has had time to settle.
   task automatic write_size(input logic [SIZE_W-1:0] value);
      req_if.valid <= 1'b0;
      while (tracker.pending_count() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.note_size_write(value);
   endtask

   // Result side: stall at random, or hold off for a long stretch when
   // asked, then take one word and check it.
   initial begin : rsp_side
      int stall;
      rsp_if.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            stall = draw_gap();
            if (stall > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         tracker.check_word(rsp_if.payload);
      end
   end

   // Watchdog: count cycles with no word moving on either channel.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int sent;
      int phase;
      int phase_items;
      tracker   = new();
      idle_mode = IDLE_NONE;
      hold_rsp  = 1'b0;

      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.payload   <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset size of eight: first plain request gives the identity, then
      // advance twice, restart and advance again.
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);

      // One element: identity is already the last order, then exhausted,
      // and a restart while exhausted still wins.
      write_size(4'd1);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);

      // Size zero acts as one.
      write_size(4'd0);
      send_request(1'b0);
      send_request(1'b0);

      // All ones clamps to the full element count.
      write_size(4'd15);
      send_request(1'b0);

      // Two elements: identity, descending, exhausted, restart, descending.
      idle_mode = IDLE_SPARSE;
      write_size(4'd2);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);

      // Three elements: walk all six orders into exhaustion, then restart.
      idle_mode = IDLE_FULL;
      write_size(4'd3);
      repeat (7) send_request(1'b0);
      send_request(1'b1);

      // Random phases: new size, new idle mode, a run of mostly plain
      // requests with the odd restart. Phase two holds the result side off
      // at full size while requests keep coming, so the queue backs up.
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_REQUESTS) begin
         write_size(phase == 2 ? 4'd8 : pick_size());
         idle_mode = idle_kind_type'(phase % 3);
         if (phase == 2) begin
            idle_mode = IDLE_NONE;
            hold_rsp  = 1'b1;
         end
         phase_items = $urandom_range(4, 30);
         if (phase_items > RANDOM_REQUESTS - sent) phase_items = RANDOM_REQUESTS - sent;
         repeat (phase_items) begin
            send_request($urandom_range(0, 15) == 0);
            sent++;
         end
         phase++;
      end

      // Drain, then give any stray word time to show up.
      req_if.valid <= 1'b0;
      while (tracker.pending_count() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("summary: %0d requests in %0d random phases plus directed cases, %0d words checked",
               tracker.requests_noted, phase, tracker.words_checked);
      $display("summary: %0d whole orders, %0d descending, %0d exhausted replies, %0d mismatches",
               tracker.orders_seen, tracker.descending_seen, tracker.exhausted_seen,
               tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.pending_count() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/lpg_pkg.sv
sv/lpg_stream_if.sv
sv/lpg_front.sv
sv/lpg_cmd_queue.sv
sv/lpg_back.sv
sv/lexicographic_permutation_generator.sv
tb/sv/lpg_tb_pkg.sv
tb/sv/lexicographic_permutation_generator_tb.sv
